[rtl/sfd_pkg.sv]
package sfd_pkg;

	localparam int BYTE_W  = 8;
	localparam int CFG_W   = 5;
	localparam int IDX_W   = 4;
	localparam int VAL_W   = 16;

	localparam int MAX_SENSORS_DEF = 16;
	localparam int CHUNK_LIMIT_DEF = 255;

	localparam logic [CFG_W-1:0] SENSOR_COUNT_RST = CFG_W'(16);

	localparam logic [BYTE_W-1:0] START_BYTE   = 8'h02;
	localparam logic [BYTE_W-1:0] COMMA_BYTE   = 8'h2C;
	localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

	typedef enum logic [2:0] {
		MODE_HUNT    = 3'b001,
		MODE_FIELD   = 3'b010,
		MODE_DISCARD = 3'b100
	} mode_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              end_of_chunk;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] sensor_index;
		logic [VAL_W-1:0] sensor_value;
		logic             last_sensor;
	} result_t;

	// Handshake between the pipeline stages.
	typedef struct packed {
		logic go;       // the item in stage one is consumed this cycle
		logic has_res;  // that item produces a result
	} step_t;

endpackage

[rtl/sensor_frame_deframer_unit.sv]
// Channel   Direction  Handshake                  Payload
// input     in         in_valid / in_stall        data_byte, end_of_chunk
// result    out        out_valid / out_stall      sensor_index, sensor_value, last_sensor
// config    in         cfg_valid / cfg_ready      sensor_count
//
// One byte is accepted per cycle while in_stall is low; the result register takes a byte's result
// as the byte leaves the input register, and the parser update between the two is combinational.
// Reset is asynchronous and active low; the parser returns to the hunt with a count of 16.
// While the result register is held by out_stall, bytes that yield no result keep flowing;
// in_stall rises while the byte in the input register would also produce a result.
module sensor_frame_deframer_unit #(
	parameter int MAX_SENSORS = sfd_pkg::MAX_SENSORS_DEF,
	parameter int CHUNK_LIMIT = sfd_pkg::CHUNK_LIMIT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [sfd_pkg::BYTE_W-1:0]  data_byte,
	input  logic                        end_of_chunk,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [sfd_pkg::IDX_W-1:0]   sensor_index,
	output logic [sfd_pkg::VAL_W-1:0]   sensor_value,
	output logic                        last_sensor,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [sfd_pkg::CFG_W-1:0]   sensor_count
);
	import sfd_pkg::*;

	item_t   in_item, s1_item;
	logic    s1_valid;
	logic    has_res;
	logic    out_free;
	result_t res, out_res;
	step_t   ctl;

	assign in_item.data_byte    = data_byte;
	assign in_item.end_of_chunk = end_of_chunk;

	assign cfg_ready = 1'b1;

	// A request leaves stage one unless its result has nowhere to go.
	assign ctl.has_res = has_res;
	assign ctl.go      = s1_valid && (!has_res || out_free);

	sfd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.go       (ctl.go),
		.s1_valid (s1_valid),
		.s1_item  (s1_item)
	);

	sfd_parse #(
		.MAX_SENSORS (MAX_SENSORS),
		.CHUNK_LIMIT (CHUNK_LIMIT)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_data  (sensor_count),
		.item      (s1_item),
		.step      (ctl.go),
		.has_res   (has_res),
		.res       (res)
	);

	sfd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.res       (res),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign sensor_index = out_res.sensor_index;
	assign sensor_value = out_res.sensor_value;
	assign last_sensor  = out_res.last_sensor;

endmodule

[rtl/sfd_in_stage.sv]
module sfd_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  sfd_pkg::item_t in_item,
	input  logic           go,
	output logic           s1_valid,
	output sfd_pkg::item_t s1_item
);
	import sfd_pkg::*;

	logic  valid_s1;
	item_t item_s1;

	// Stage one may be refilled in the same cycle that its request moves on.
	assign in_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	assign s1_valid = valid_s1;
	assign s1_item  = item_s1;

endmodule

[rtl/sfd_parse.sv]
module sfd_parse #(
	parameter int MAX_SENSORS = sfd_pkg::MAX_SENSORS_DEF,
	parameter int CHUNK_LIMIT = sfd_pkg::CHUNK_LIMIT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [sfd_pkg::CFG_W-1:0]   cfg_data,
	input  sfd_pkg::item_t              item,
	input  logic                        step,
	output logic                        has_res,
	output sfd_pkg::result_t            res
);
	import sfd_pkg::*;

	localparam int NS_W  = $clog2(MAX_SENSORS + 1);
	localparam int POS_W = $clog2(CHUNK_LIMIT + 1);
	localparam int CW    = ((NS_W > CFG_W) ? NS_W : CFG_W) + 1;

	mode_t             mode_q, mode_d;
	logic [1:0]        fbc_q, fbc_d;
	logic [BYTE_W-1:0] high_q, low_q;
	logic [NS_W-1:0]   next_q, next_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [CFG_W-1:0]  count_q;

	logic          in_window;
	logic          is_term;
	logic [CW-1:0] cfg_ext, cnt, next_inc;
	logic          last;
	logic          load_high, load_low;

	assign in_window = pos_q < POS_W'(CHUNK_LIMIT);
	assign is_term   = (item.data_byte == COMMA_BYTE) || (item.data_byte == NEWLINE_BYTE);

	// A count of zero behaves as one and anything above the capacity is clamped.
	assign cfg_ext  = CW'(count_q);
	always_comb begin
		if (cfg_ext == '0) begin
			cnt = CW'(1);
		end else if (cfg_ext > CW'(MAX_SENSORS)) begin
			cnt = CW'(MAX_SENSORS);
		end else begin
			cnt = cfg_ext;
		end
	end
	assign next_inc = CW'(next_q) + CW'(1);
	assign last     = next_inc >= cnt;

	assign has_res = in_window && (mode_q == MODE_FIELD) && is_term && (fbc_q == 2'd2);

	assign res.sensor_index = IDX_W'(next_q);
	assign res.sensor_value = {high_q, low_q};
	assign res.last_sensor  = last;

	always_comb begin
		mode_d    = mode_q;
		fbc_d     = fbc_q;
		next_d    = next_q;
		pos_d     = pos_q;
		load_high = 1'b0;
		load_low  = 1'b0;
		if (in_window) begin
			pos_d = pos_q + POS_W'(1);
			case (mode_q)
				MODE_HUNT: begin
					if (item.data_byte == START_BYTE) begin
						mode_d = MODE_FIELD;
						fbc_d  = 2'd0;
					end else if (item.data_byte == NEWLINE_BYTE) begin
						mode_d = MODE_DISCARD;
					end
				end
				MODE_FIELD: begin
					if (is_term) begin
						if (fbc_q == 2'd2) begin
							next_d = NS_W'(next_inc);
							fbc_d  = 2'd0;
							if (last) begin
								mode_d = MODE_DISCARD;
							end
						end else begin
							mode_d = MODE_DISCARD;
						end
					end else if (fbc_q == 2'd0) begin
						load_high = 1'b1;
						fbc_d     = 2'd1;
					end else if (fbc_q == 2'd1) begin
						load_low = 1'b1;
						fbc_d    = 2'd2;
					end else begin
						mode_d = MODE_DISCARD;
					end
				end
				default: begin
				end
			endcase
		end
		// The chunk end always returns the parser to a clean hunt.
		if (item.end_of_chunk) begin
			mode_d = MODE_HUNT;
			fbc_d  = 2'd0;
			next_d = '0;
			pos_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_HUNT;
			fbc_q   <= 2'd0;
			next_q  <= '0;
			pos_q   <= '0;
			count_q <= SENSOR_COUNT_RST;
		end else begin
			if (step) begin
				mode_q <= mode_d;
				fbc_q  <= fbc_d;
				next_q <= next_d;
				pos_q  <= pos_d;
			end
			if (cfg_write) begin
				count_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && load_high) begin
			high_q <= item.data_byte;
		end
		if (step && load_low) begin
			low_q <= item.data_byte;
		end
	end

endmodule

[rtl/sfd_out_stage.sv]
module sfd_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  sfd_pkg::step_t   ctl,
	input  sfd_pkg::result_t res,
	output logic             out_free,
	output logic             out_valid,
	input  logic             out_stall,
	output sfd_pkg::result_t out_res
);
	import sfd_pkg::*;

	logic    valid_q;
	result_t res_q;
	logic    load;

	assign out_free = !valid_q || !out_stall;
	assign load     = ctl.go && ctl.has_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
module testbench;
	import sfd_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int IDLE_PCT     = 23;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              in_valid     = 1'b0;
	logic              in_stall;
	logic [BYTE_W-1:0] data_byte    = '0;
	logic              end_of_chunk = 1'b0;
	logic              out_valid;
	logic              out_stall    = 1'b0;
	logic [IDX_W-1:0]  sensor_index;
	logic [VAL_W-1:0]  sensor_value;
	logic              last_sensor;
	logic              cfg_valid    = 1'b0;
	logic              cfg_ready;
	logic [CFG_W-1:0]  sensor_count = '0;

	// Local copy of the deframer state.
	mode_t             frame_mode;
	logic [1:0]        field_len;
	logic [BYTE_W-1:0] high_hold;
	logic [BYTE_W-1:0] low_hold;
	logic [IDX_W-1:0]  next_idx;
	int                chunk_pos;
	logic [CFG_W-1:0]  count_reg;

	result_t           pending_readings[$];
	result_t           oldest_reading;
	logic [BYTE_W-1:0] chunk_bytes[$];

	bit                no_idle = 1'b0;
	int                fault_count = 0;
	int                bytes_sent = 0;
	int                readings_checked = 0;
	int                cfg_writes = 0;
	int                cycle_count = 0;

	sensor_frame_deframer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.end_of_chunk (end_of_chunk),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sensor_index (sensor_index),
		.sensor_value (sensor_value),
		.last_sensor  (last_sensor),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.sensor_count (sensor_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int eff_count();
		if (count_reg == 0)
			return 1;
		if (int'(count_reg) > MAX_SENSORS_DEF)
			return MAX_SENSORS_DEF;
		return int'(count_reg);
	endfunction

	function automatic void log_fault(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("error: %s", msg);
	endfunction

	// Advances the local state by one accepted byte and queues any reading it yields.
	function automatic void track_byte(input logic [BYTE_W-1:0] b, input logic eoc);
		result_t r;
		if (chunk_pos < CHUNK_LIMIT_DEF) begin
			chunk_pos++;
			case (frame_mode)
			MODE_HUNT: begin
				if (b == START_BYTE) begin
					frame_mode = MODE_FIELD;
					field_len = 2'd0;
				end else if (b == NEWLINE_BYTE) begin
					frame_mode = MODE_DISCARD;
				end
			end
			MODE_FIELD: begin
				if (b == COMMA_BYTE || b == NEWLINE_BYTE) begin
					if (field_len == 2'd2) begin
						r.sensor_index = next_idx;
						r.sensor_value = {high_hold, low_hold};
						r.last_sensor = (int'(next_idx) + 1 >= eff_count());
						pending_readings.push_back(r);
						next_idx++;
						field_len = 2'd0;
						if (r.last_sensor)
							frame_mode = MODE_DISCARD;
					end else begin
						frame_mode = MODE_DISCARD;
					end
				end else if (field_len == 2'd0) begin
					high_hold = b;
					field_len = 2'd1;
				end else if (field_len == 2'd1) begin
					low_hold = b;
					field_len = 2'd2;
				end else begin
					frame_mode = MODE_DISCARD;
				end
			end
			default: ;
			endcase
		end
		if (eoc) begin
			frame_mode = MODE_HUNT;
			field_len = 2'd0;
			next_idx = '0;
			chunk_pos = 0;
		end
	endfunction

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eoc);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_chunk <= eoc;
		do @(posedge clk); while (in_stall);
		track_byte(b, eoc);
		bytes_sent++;
	endtask

	task automatic send_chunk();
		foreach (chunk_bytes[i])
			send_byte(chunk_bytes[i], i == chunk_bytes.size() - 1);
		chunk_bytes.delete();
	endtask

	// Stops the input, waits for every reading, then lets bytes without results clear.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_sensor_count(input logic [CFG_W-1:0] v);
		settle();
		cfg_valid <= 1'b1;
		sensor_count <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		count_reg = v;
		cfg_writes++;
	endtask

	function automatic logic [BYTE_W-1:0] field_byte();
		logic [BYTE_W-1:0] b;
		b = BYTE_W'($urandom_range(255));
		if ($urandom_range(99) >= 4)
			while (b == COMMA_BYTE || b == NEWLINE_BYTE)
				b = BYTE_W'($urandom_range(255));
		return b;
	endfunction

	function automatic logic [BYTE_W-1:0] filler_byte();
		return 8'h41 + BYTE_W'($urandom_range(20));
	endfunction

	function automatic logic [BYTE_W-1:0] terminator();
		return $urandom_range(1) ? COMMA_BYTE : NEWLINE_BYTE;
	endfunction

	task automatic test_hunt_and_abort();
		// A newline while hunting throws away the start byte that follows it.
		chunk_bytes = '{8'h41, NEWLINE_BYTE, START_BYTE, 8'h31, 8'h32, COMMA_BYTE};
		send_chunk();
		chunk_bytes = '{8'h55, START_BYTE, 8'h00, 8'h00, COMMA_BYTE,
			8'hFF, 8'hFF, NEWLINE_BYTE};
		send_chunk();
	endtask

	task automatic test_bad_lengths();
		chunk_bytes = '{START_BYTE, COMMA_BYTE};
		send_chunk();
		chunk_bytes = '{START_BYTE, 8'h11, NEWLINE_BYTE};
		send_chunk();
		chunk_bytes = '{START_BYTE, 8'h11, 8'h22, 8'h33, COMMA_BYTE};
		send_chunk();
		// Start bytes inside a field are plain data.
		chunk_bytes = '{START_BYTE, START_BYTE, START_BYTE, COMMA_BYTE};
		send_chunk();
	endtask

	task automatic test_cut_frame();
		chunk_bytes = '{START_BYTE, 8'hAB, 8'hCD, COMMA_BYTE, 8'h12};
		send_chunk();
		chunk_bytes = '{START_BYTE, 8'h01, 8'h02, COMMA_BYTE};
		send_chunk();
	endtask

	task automatic test_count_extremes();
		write_sensor_count(CFG_W'(1));
		chunk_bytes = '{START_BYTE, 8'h7F, 8'h80, NEWLINE_BYTE, 8'h01, 8'h02, COMMA_BYTE};
		send_chunk();
		write_sensor_count(CFG_W'(0));
		chunk_bytes = '{START_BYTE, 8'h80, 8'h7F, COMMA_BYTE, 8'h03, 8'h04, COMMA_BYTE};
		send_chunk();
	endtask

	task automatic test_chunk_limit();
		write_sensor_count(CFG_W'(16));
		repeat (CHUNK_LIMIT_DEF - 5)
			chunk_bytes.push_back(filler_byte());
		// The second field straddles the byte limit and must be ignored.
		chunk_bytes = {chunk_bytes, START_BYTE, 8'h61, 8'h62, COMMA_BYTE,
			8'h63, 8'h64, COMMA_BYTE, 8'h65};
		send_chunk();
	endtask

	task automatic test_midframe_write();
		send_byte(START_BYTE, 1'b0);
		send_byte(8'h10, 1'b0);
		send_byte(8'h20, 1'b0);
		send_byte(COMMA_BYTE, 1'b0);
		write_sensor_count(CFG_W'(2));
		send_byte(8'h30, 1'b0);
		send_byte(8'h40, 1'b0);
		send_byte(COMMA_BYTE, 1'b0);
		send_byte(8'h50, 1'b0);
		send_byte(8'h60, 1'b0);
		send_byte(COMMA_BYTE, 1'b0);
		send_byte(8'h00, 1'b1);
	endtask

	task automatic random_frames(input int n_bytes);
		int first;
		int kind;
		int fields;
		first = bytes_sent;
		while (bytes_sent - first < n_bytes) begin
			kind = $urandom_range(99);
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(3, 1)) chunk_bytes.push_back(filler_byte());
			if (kind < 85) begin
				chunk_bytes.push_back(START_BYTE);
				fields = $urandom_range(eff_count() + 1, 1);
				repeat (fields) begin
					chunk_bytes.push_back(field_byte());
					chunk_bytes.push_back(field_byte());
					chunk_bytes.push_back(terminator());
				end
				// Some frames carry one field of the wrong length.
				if (kind >= 72) begin
					repeat ($urandom_range(1) ? 1 : 3) chunk_bytes.push_back(field_byte());
					chunk_bytes.push_back(terminator());
				end
				if ($urandom_range(2) == 0)
					repeat ($urandom_range(3, 1))
						chunk_bytes.push_back(BYTE_W'($urandom_range(255)));
			end else begin
				repeat ($urandom_range(12, 1))
					chunk_bytes.push_back($urandom_range(3) == 0 ? START_BYTE
						: BYTE_W'($urandom_range(255)));
			end
			send_chunk();
		end
	endtask

	task automatic test_random_settings();
		logic [CFG_W-1:0] plan[8];
		plan = '{CFG_W'(16), CFG_W'(1), CFG_W'(31), CFG_W'(0), CFG_W'(17),
			CFG_W'($urandom_range(15, 2)), CFG_W'($urandom_range(31)),
			CFG_W'($urandom_range(16, 1))};
		foreach (plan[i]) begin
			write_sensor_count(plan[i]);
			no_idle = (i == 3);
			random_frames(55);
			no_idle = 1'b0;
		end
	endtask

	always @(posedge clk)
		out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_readings.size() == 0) begin
				log_fault($sformatf("unexpected reading index %0d value %h last %0b",
					sensor_index, sensor_value, last_sensor));
			end else begin
				oldest_reading = pending_readings.pop_front();
				if (sensor_index !== oldest_reading.sensor_index ||
				    sensor_value !== oldest_reading.sensor_value ||
				    last_sensor !== oldest_reading.last_sensor)
					log_fault($sformatf("expected index %0d value %h last %0b, got %0d %h %0b",
						oldest_reading.sensor_index, oldest_reading.sensor_value,
						oldest_reading.last_sensor, sensor_index, sensor_value,
						last_sensor));
				readings_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles with %0d readings outstanding",
				cycle_count, pending_readings.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		count_reg = SENSOR_COUNT_RST;
		frame_mode = MODE_HUNT;
		field_len = 2'd0;
		high_hold = '0;
		low_hold = '0;
		next_idx = '0;
		chunk_pos = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_hunt_and_abort();
		test_bad_lengths();
		test_cut_frame();
		test_count_extremes();
		test_chunk_limit();
		test_midframe_write();
		test_random_settings();
		settle();

		$display("%0d bytes sent, %0d readings checked, %0d count writes, %0d faults",
			bytes_sent, readings_checked, cfg_writes, fault_count);
		$display("covered hunt abort, field length errors, chunk limit, counts 0 to 31");
		if (fault_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
